// ===== design/ttb_pkg.sv =====
// Package for the triangle tangent basis block: shared types and constants.
// Used by ttb_front, ttb_back and triangle_tangent_basis_top.
package ttb_pkg;

    // Bits of a differentiated coordinate at the widest parameter value.
    localparam int DW = 49;

    // One triangle handed from the front to the back: edges and UV deltas.
    typedef struct packed {
        logic signed [DW-1:0] e1x;
        logic signed [DW-1:0] e1y;
        logic signed [DW-1:0] e1z;
        logic signed [DW-1:0] e2x;
        logic signed [DW-1:0] e2y;
        logic signed [DW-1:0] e2z;
        logic signed [DW-1:0] du1;
        logic signed [DW-1:0] dv1;
        logic signed [DW-1:0] du2;
        logic signed [DW-1:0] dv2;
    } tri_t;

    // One finished result.
    typedef struct packed {
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic signed [15:0] tz;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic signed [15:0] bz;
        logic               degen;
    } res_t;

endpackage

// ===== design/ttb_front.sv =====
// Front part: groups vertices in threes and forms edge vectors and UV deltas.
// Depends on ttb_pkg.
module ttb_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_WIDTH-1:0] px,
    input  logic [COORD_WIDTH-1:0] py,
    input  logic [COORD_WIDTH-1:0] pz,
    input  logic [COORD_WIDTH-1:0] tu,
    input  logic [COORD_WIDTH-1:0] tv,
    output logic                   q_valid,
    input  logic                   q_ready,
    output ttb_pkg::tri_t          q_data
);
    import ttb_pkg::*;

    logic [1:0] phase_reg;
    logic [COORD_WIDTH-1:0] p0_reg [5];
    logic [COORD_WIDTH-1:0] p1_reg [5];
    // Two-entry queue toward the back part.
    tri_t       fifo_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    tri_t       tri_next;
    logic       acc, push, pop;

    function automatic logic signed [DW-1:0] dif(input logic [COORD_WIDTH-1:0] a,
                                                 input logic [COORD_WIDTH-1:0] b);
        logic signed [DW-1:0] ea, eb;
        ea = DW'($signed(a));
        eb = DW'($signed(b));
        return ea - eb;
    endfunction

    assign in_ready = (phase_reg != 2'd2) || (cnt_reg != 2'd2);
    assign acc  = in_valid && in_ready;
    assign push = acc && (phase_reg == 2'd2);
    assign pop  = q_valid && q_ready;
    assign q_valid = cnt_reg != 2'd0;
    assign q_data  = fifo_reg[rd_ptr_reg];

    // Differences against the first vertex of the group.
    always_comb begin
        tri_next.e1x = dif(p1_reg[0], p0_reg[0]);
        tri_next.e1y = dif(p1_reg[1], p0_reg[1]);
        tri_next.e1z = dif(p1_reg[2], p0_reg[2]);
        tri_next.e2x = dif(px, p0_reg[0]);
        tri_next.e2y = dif(py, p0_reg[1]);
        tri_next.e2z = dif(pz, p0_reg[2]);
        tri_next.du1 = dif(p1_reg[3], p0_reg[3]);
        tri_next.dv1 = dif(p1_reg[4], p0_reg[4]);
        tri_next.du2 = dif(tu, p0_reg[3]);
        tri_next.dv2 = dif(tv, p0_reg[4]);
    end

    // Vertex store, phase counter and queue.
    always_ff @(posedge aclk) begin
        if (acc && phase_reg == 2'd0) begin
            p0_reg[0] <= px; p0_reg[1] <= py; p0_reg[2] <= pz;
            p0_reg[3] <= tu; p0_reg[4] <= tv;
        end
        if (acc && phase_reg == 2'd1) begin
            p1_reg[0] <= px; p1_reg[1] <= py; p1_reg[2] <= pz;
            p1_reg[3] <= tu; p1_reg[4] <= tv;
        end
        if (push) fifo_reg[wr_ptr_reg] <= tri_next;
        if (!aresetn) begin
            phase_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (acc) phase_reg <= (phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== design/ttb_back.sv =====
// Back part: sequencer over one shared multiplier, square root and divider.
// Depends on ttb_pkg.
module ttb_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  ttb_pkg::tri_t q_data,
    output logic          r_valid,
    input  logic          r_ready,
    output ttb_pkg::res_t r_data
);
    import ttb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_NORM, S_SQRT, S_DIV, S_OUT
    } state_t;

    localparam int PW = 2 * DW;        // product width
    localparam int AW = PW + 1;        // sum of two products

    state_t state_reg;
    tri_t   t_reg;
    // Product schedule: index selects the operand pair.
    logic [3:0] mi_reg;
    logic [1:0] mstep_reg;             // partial product of the current multiply
    logic [PW-1:0] prod_reg;           // product magnitude
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] v_reg [6];   // tx ty tz bx by bz
    logic signed [AW-1:0] det_reg;
    logic [1:0] half_reg;              // normalize step: 0 magnitudes, 1 shift, 2 square sum
    // Normalize state.
    logic       vec_reg;               // 0 tangent, 1 bitangent
    logic [AW-1:0] mag_reg [3];
    logic [30:0]   sm_reg [3];
    logic [1:0]    ci_reg;
    logic [63:0]   sum_reg;
    logic [63:0]   rem_reg, root_reg, bit_reg;
    logic [5:0]    cnt_reg;
    logic [47:0]   num_reg, quo_reg;
    logic [48:0]   dr_reg;
    logic [15:0]   out_reg [6];
    logic          degen_reg;
    logic          neg_reg;

    // Operands of the shared multiplier.
    logic signed [DW-1:0] ma, mb;
    always_comb begin
        ma = q_data.du1; mb = q_data.dv2;
        case (mi_reg)
            4'd0: begin ma = t_reg.du1; mb = t_reg.dv2; end
            4'd1: begin ma = t_reg.dv1; mb = t_reg.du2; end
            4'd2: begin ma = t_reg.dv2; mb = t_reg.e1x; end
            4'd3: begin ma = t_reg.dv1; mb = t_reg.e2x; end
            4'd4: begin ma = t_reg.dv2; mb = t_reg.e1y; end
            4'd5: begin ma = t_reg.dv1; mb = t_reg.e2y; end
            4'd6: begin ma = t_reg.dv2; mb = t_reg.e1z; end
            4'd7: begin ma = t_reg.dv1; mb = t_reg.e2z; end
            4'd8: begin ma = t_reg.du1; mb = t_reg.e2x; end
            4'd9: begin ma = t_reg.du2; mb = t_reg.e1x; end
            4'd10: begin ma = t_reg.du1; mb = t_reg.e2y; end
            4'd11: begin ma = t_reg.du2; mb = t_reg.e1y; end
            4'd12: begin ma = t_reg.du1; mb = t_reg.e2z; end
            4'd13: begin ma = t_reg.du2; mb = t_reg.e1z; end
            default: begin ma = t_reg.du1; mb = t_reg.dv2; end
        endcase
    end

    // Operand magnitudes, multiplied as four 24 by 24 partial products.
    logic [47:0]          ua, ub;
    logic [23:0]          pa, pb;
    logic [47:0]          pp;
    logic [6:0]           pshift;
    logic [PW-1:0]        pp_sh;
    logic                 psign;
    logic signed [PW-1:0] prod_s;
    assign ua = ma[DW-1] ? 48'(-ma) : 48'(ma);
    assign ub = mb[DW-1] ? 48'(-mb) : 48'(mb);
    assign pa = mstep_reg[0] ? ua[47:24] : ua[23:0];
    assign pb = mstep_reg[1] ? ub[47:24] : ub[23:0];
    assign pp = pa * pb;
    always_comb begin
        case (mstep_reg)
            2'd0: pshift = 7'd0;
            2'd3: pshift = 7'd48;
            default: pshift = 7'd24;
        endcase
    end
    assign pp_sh  = PW'(pp) << pshift;
    assign psign  = ma[DW-1] ^ mb[DW-1];
    assign prod_s = psign ? -$signed(prod_reg) : $signed(prod_reg);

    // Bit length of the largest magnitude, found one component per cycle.
    function automatic logic [6:0] blen(input logic [AW-1:0] v);
        logic [6:0] n;
        n = 7'd0;
        for (int i = 0; i < AW; i++) if (v[i]) n = 7'(i + 1);
        return n;
    endfunction

    logic [6:0] maxlen_reg;
    logic [6:0] shamt;
    assign shamt = (maxlen_reg > 7'd31) ? maxlen_reg - 7'd31 : 7'd0;

    // Component slot of the vector being normalized.
    logic [2:0] vidx;
    assign vidx = vec_reg ? 3'd3 + {1'b0, ci_reg} : {1'b0, ci_reg};

    logic signed [AW-1:0] vsel;
    logic [AW-1:0]        vabs;
    logic                 vflip;
    assign vsel  = v_reg[vidx];
    assign vabs  = vsel[AW-1] ? AW'(-vsel) : AW'(vsel);
    assign vflip = vsel[AW-1] != det_reg[AW-1];

    // Square of one scaled component.
    logic [61:0] sq;
    assign sq = sm_reg[ci_reg] * sm_reg[ci_reg];

    // Square root step values.
    logic [63:0] rb;
    assign rb = root_reg + bit_reg;

    // Division step: numerator small*65536 + L over 2L, restoring.
    logic [48:0] trial;
    assign trial = {dr_reg[47:0], num_reg[47]} - {root_reg[47:0], 1'b0};

    logic [47:0] qsat;
    logic [15:0] qout;
    assign qsat = (quo_reg > 48'd32768) ? 48'd32768 : quo_reg;
    always_comb begin
        if (neg_reg) qout = 16'(-qsat);
        else qout = (qsat > 48'd32767) ? 16'd32767 : qsat[15:0];
    end

    assign q_ready = state_reg == S_IDLE;
    assign r_valid = state_reg == S_OUT;
    assign r_data  = '{tx: out_reg[0], ty: out_reg[1], tz: out_reg[2],
                       bx: out_reg[3], by: out_reg[4], bz: out_reg[5],
                       degen: degen_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE: if (q_valid) begin
                    t_reg <= q_data;
                    mi_reg <= 4'd0;
                    mstep_reg <= 2'd0;
                    half_reg <= 2'd0;
                    state_reg <= S_MUL;
                end
                // One product from four partial products, then combine pairs.
                S_MUL: begin
                    prod_reg <= (mstep_reg == 2'd0) ? pp_sh : prod_reg + pp_sh;
                    mstep_reg <= mstep_reg + 2'd1;
                    if (mstep_reg == 2'd3) state_reg <= S_ACC;
                end
                S_ACC: begin
                    if (!mi_reg[0]) acc_reg <= AW'(prod_s);
                    else begin
                        if (mi_reg == 4'd1) begin
                            det_reg <= acc_reg - AW'(prod_s);
                            degen_reg <= (acc_reg == AW'(prod_s));
                        end else
                            v_reg[3'((mi_reg - 4'd3) >> 1)] <= acc_reg - AW'(prod_s);
                    end
                    if (mi_reg == 4'd13) begin
                        vec_reg <= 1'b0; ci_reg <= 2'd0; maxlen_reg <= 7'd0;
                        half_reg <= 2'd0;
                        state_reg <= S_NORM;
                    end else begin
                        mi_reg <= mi_reg + 4'd1;
                        state_reg <= S_MUL;
                    end
                end
                // half 0: magnitudes and max length; half 1: shift; half 2: square sum.
                S_NORM: begin
                    if (half_reg == 2'd0) begin
                        mag_reg[ci_reg] <= vabs;
                        if (blen(vabs) > maxlen_reg) maxlen_reg <= blen(vabs);
                        if (ci_reg == 2'd2) begin
                            ci_reg <= 2'd0; half_reg <= 2'd1; sum_reg <= '0;
                        end else ci_reg <= ci_reg + 2'd1;
                    end else if (half_reg == 2'd1) begin
                        sm_reg[ci_reg] <= 31'(mag_reg[ci_reg] >> shamt);
                        half_reg <= 2'd2;
                    end else begin
                        sum_reg <= sum_reg + 64'(sq);
                        if (ci_reg == 2'd2) begin
                            rem_reg <= sum_reg + 64'(sq);
                            root_reg <= '0;
                            bit_reg <= 64'd1 << 62;
                            state_reg <= S_SQRT;
                        end else begin
                            ci_reg <= ci_reg + 2'd1; half_reg <= 2'd1;
                        end
                    end
                end
                // One root bit per cycle.
                S_SQRT: begin
                    if (bit_reg == '0) begin
                        ci_reg <= 2'd0; cnt_reg <= 6'd0;
                        num_reg <= {1'b0, sm_reg[0], 16'd0} + 48'(root_reg);
                        dr_reg <= '0; quo_reg <= '0;
                        state_reg <= S_DIV;
                    end else begin
                        if (rem_reg >= rb) begin
                            rem_reg <= rem_reg - rb;
                            root_reg <= (root_reg >> 1) + bit_reg;
                        end else root_reg <= root_reg >> 1;
                        bit_reg <= bit_reg >> 2;
                    end
                end
                // One quotient bit per cycle, then sign and saturate.
                S_DIV: begin
                    if (cnt_reg == 6'd48) begin
                        out_reg[vidx] <= (root_reg == '0) ? 16'd0 : qout;
                        cnt_reg <= 6'd0; dr_reg <= '0; quo_reg <= '0;
                        if (ci_reg == 2'd2) begin
                            if (vec_reg) state_reg <= S_OUT;
                            else begin
                                vec_reg <= 1'b1; ci_reg <= 2'd0;
                                maxlen_reg <= 7'd0; half_reg <= 2'd0;
                                state_reg <= S_NORM;
                            end
                        end else begin
                            ci_reg <= ci_reg + 2'd1;
                            num_reg <= {1'b0, sm_reg[ci_reg + 2'd1], 16'd0}
                                       + 48'(root_reg);
                        end
                    end else begin
                        if (cnt_reg == 6'd0) neg_reg <= vflip;
                        if (!trial[48]) begin
                            dr_reg <= trial; quo_reg <= {quo_reg[46:0], 1'b1};
                        end else begin
                            dr_reg <= {dr_reg[47:0], num_reg[47]};
                            quo_reg <= {quo_reg[46:0], 1'b0};
                        end
                        num_reg <= {num_reg[46:0], 1'b0};
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_OUT: if (r_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/triangle_tangent_basis_top.sv =====
// Top level of the triangle tangent basis block.
// Depends on ttb_pkg, ttb_front and ttb_back.
//
//  channel  dir  payload
//  s_axis   in   vertex: pos_x pos_y pos_z tex_u tex_v
//  m_axis   out  tangent, bitangent, degenerate flag
//
// Vertices are taken one per cycle while the queue has room; every third
// vertex completes a triangle. The back works on one triangle at a time:
// fourteen products of four partial products and a combine each, then per
// vector the scaling, a square root and three divisions; it takes the next
// triangle only after m_axis has taken the result.
// Reset is synchronous, active low, and clears the phase, the queue and the back's state.
// Two triangles may queue while a result waits for m_axis_tready.
module triangle_tangent_basis_top #(
    parameter int COORD_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v from bit 0 up, zero fill to bytes.
    input  logic [((5*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tangent_x/y/z, bitangent_x/y/z from bit 0 up.
    output logic [95:0]  m_axis_tdata,
    // degenerate.
    output logic         m_axis_tuser
);
    import ttb_pkg::*;

    logic  q_valid, q_ready;
    tri_t  q_data;
    res_t  r;

    ttb_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .px(s_axis_tdata[COORD_WIDTH-1:0]),
        .py(s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .pz(s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
        .tu(s_axis_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH]),
        .tv(s_axis_tdata[5*COORD_WIDTH-1:4*COORD_WIDTH]),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    ttb_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .r_valid(m_axis_tvalid), .r_ready(m_axis_tready), .r_data(r)
    );

    assign m_axis_tdata = {r.bz, r.by, r.bx, r.tz, r.ty, r.tx};
    assign m_axis_tuser = r.degen;
endmodule

// ===== dv/triangle_tangent_basis_checker.sv =====
// Checker for the triangle tangent basis block: watches both streams,
// predicts each triangle's unit tangent and bitangent, and compares.
// Depends on ttb_pkg for the result type.
`timescale 1ns / 1ps

module triangle_tangent_basis_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [95:0]  m_axis_tdata,
    input  logic         m_axis_tuser,
    output int           fail_count,
    output int           pending,
    output int           results_seen,
    output int           degenerate_seen
);
    import ttb_pkg::*;

    // Predictor state: vertices held so far in the current triangle.
    logic [1:0]         held_count;
    logic signed [31:0] vert0_pos [3];
    logic signed [31:0] vert0_tex [2];
    logic signed [31:0] vert1_pos [3];
    logic signed [31:0] vert1_tex [2];

    res_t basis_queue [$];

    assign pending = basis_queue.size();

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        fail_count++;
    endtask

    function automatic int bit_length(input logic [127:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 128; i++) begin
            if (v[i]) n = i + 1;
        end
        return n;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scales a wide vector down to 31 bits, then divides by its length in Q1.15.
    function automatic logic [47:0] unit_q15(input logic signed [127:0] c0,
                                             input logic signed [127:0] c1,
                                             input logic signed [127:0] c2,
                                             input logic flip);
        logic signed [127:0] cv [3];
        logic [127:0] mag [3];
        logic         ng [3];
        logic [63:0]  sm [3];
        logic [63:0]  sum, len, q;
        logic [47:0]  r;
        int maxlen, s, n;
        cv[0] = c0;
        cv[1] = c1;
        cv[2] = c2;
        maxlen = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            ng[i] = cv[i][127];
            mag[i] = ng[i] ? -cv[i] : cv[i];
            n = bit_length(mag[i]);
            if (n > maxlen) maxlen = n;
        end
        s = (maxlen > 31) ? maxlen - 31 : 0;
        for (int i = 0; i < 3; i++) begin
            sm[i] = 64'(mag[i] >> s);
            sum = sum + sm[i] * sm[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = 0;
            if (len != 0) q = (sm[i] * 64'd65536 + len) / (64'd2 * len);
            if (q > 32768) q = 32768;
            if (ng[i] != flip) r[16*i +: 16] = 16'(-q);
            else r[16*i +: 16] = (q > 32767) ? 16'd32767 : q[15:0];
        end
        return r;
    endfunction

    // Forms edges and UV deltas of one triangle and its expected basis.
    function automatic res_t tangent_basis(input logic signed [31:0] pos2 [3],
                                           input logic signed [31:0] tex2 [2]);
        logic signed [127:0] e1 [3];
        logic signed [127:0] e2 [3];
        logic signed [127:0] tg [3];
        logic signed [127:0] bt [3];
        logic signed [127:0] du1, dv1, du2, dv2, det;
        logic [47:0] tv, bv;
        logic flip;
        res_t r;
        for (int i = 0; i < 3; i++) begin
            e1[i] = 128'(vert1_pos[i]) - 128'(vert0_pos[i]);
            e2[i] = 128'(pos2[i]) - 128'(vert0_pos[i]);
        end
        du1 = 128'(vert1_tex[0]) - 128'(vert0_tex[0]);
        dv1 = 128'(vert1_tex[1]) - 128'(vert0_tex[1]);
        du2 = 128'(tex2[0]) - 128'(vert0_tex[0]);
        dv2 = 128'(tex2[1]) - 128'(vert0_tex[1]);
        det = du1 * dv2 - dv1 * du2;
        flip = det[127];
        for (int i = 0; i < 3; i++) begin
            tg[i] = dv2 * e1[i] - dv1 * e2[i];
            bt[i] = du1 * e2[i] - du2 * e1[i];
        end
        tv = unit_q15(tg[0], tg[1], tg[2], flip);
        bv = unit_q15(bt[0], bt[1], bt[2], flip);
        r.tx = tv[15:0];
        r.ty = tv[31:16];
        r.tz = tv[47:32];
        r.bx = bv[15:0];
        r.by = bv[31:16];
        r.bz = bv[47:32];
        r.degen = (det == 0);
        return r;
    endfunction

    // Track accepted vertices and queue a prediction on every third one.
    always @(posedge aclk) begin
        logic signed [31:0] p [3];
        logic signed [31:0] t [2];
        if (!aresetn) begin
            held_count <= 0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            for (int i = 0; i < 3; i++) p[i] = s_axis_tdata[32*i +: 32];
            t[0] = s_axis_tdata[96 +: 32];
            t[1] = s_axis_tdata[128 +: 32];
            if (held_count == 0) begin
                vert0_pos <= p;
                vert0_tex <= t;
                held_count <= 1;
            end else if (held_count == 1) begin
                vert1_pos <= p;
                vert1_tex <= t;
                held_count <= 2;
            end else begin
                basis_queue = {basis_queue, tangent_basis(p, t)};
                held_count <= 0;
            end
        end
    end

    // Compare each accepted result with the oldest prediction.
    initial begin
        fail_count = 0;
        results_seen = 0;
        degenerate_seen = 0;
    end

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (basis_queue.size() == 0) begin
                $display("unexpected result item %0d", results_seen);
                fail_count++;
            end else begin
                want = basis_queue.pop_front();
                if ($signed(m_axis_tdata[15:0]) != want.tx)
                    report_mismatch("tangent_x", $signed(m_axis_tdata[15:0]), want.tx);
                if ($signed(m_axis_tdata[31:16]) != want.ty)
                    report_mismatch("tangent_y", $signed(m_axis_tdata[31:16]), want.ty);
                if ($signed(m_axis_tdata[47:32]) != want.tz)
                    report_mismatch("tangent_z", $signed(m_axis_tdata[47:32]), want.tz);
                if ($signed(m_axis_tdata[63:48]) != want.bx)
                    report_mismatch("bitangent_x", $signed(m_axis_tdata[63:48]), want.bx);
                if ($signed(m_axis_tdata[79:64]) != want.by)
                    report_mismatch("bitangent_y", $signed(m_axis_tdata[79:64]), want.by);
                if ($signed(m_axis_tdata[95:80]) != want.bz)
                    report_mismatch("bitangent_z", $signed(m_axis_tdata[95:80]), want.bz);
                if (m_axis_tuser !== want.degen)
                    report_mismatch("degenerate", m_axis_tuser, want.degen);
                if (want.degen) degenerate_seen++;
            end
            results_seen++;
        end
    end

endmodule

// ===== dv/triangle_tangent_basis_top_tb.sv =====
// Testbench top for the triangle tangent basis block: drives vertex triangles
// with random stalls and gives the verdict. Depends on the block and the checker.
`timescale 1ns / 1ps

module triangle_tangent_basis_top_tb;

    localparam int TRIANGLES = 217;
    localparam int QUIET_FROM = 185;
    localparam longint CYCLE_LIMIT = 2000000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [95:0]  m_axis_tdata;
    logic         m_axis_tuser;

    int  fail_count, pending, results_seen, degenerate_seen;
    logic   quiet = 0;
    longint cycles = 0;

    always #4 aclk = ~aclk;

    triangle_tangent_basis_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    triangle_tangent_basis_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .fail_count(fail_count), .pending(pending),
        .results_seen(results_seen), .degenerate_seen(degenerate_seen)
    );

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result side stalls in random bursts until the quiet part of the run.
    always @(negedge aclk) begin
        int stall_left;
        if (quiet) begin
            m_axis_tready <= 1;
        end else if (stall_left > 0) begin
            stall_left--;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= 1;
        end
    end

    function automatic logic [31:0] edge_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'h1;
            4: return 32'hffffffff;
            default: return 32'h00010000;
        endcase
    endfunction

    function automatic logic [31:0] near_value(input int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    // Offers one vertex and holds it until the block takes it.
    task automatic send_vertex(input logic [31:0] x, y, z, u, v);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {v, u, z, y, x};
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    // One random triangle of a chosen flavor.
    task automatic send_triangle(input int flavor);
        logic [31:0] base [5];
        logic [31:0] du, dv;
        for (int i = 0; i < 5; i++) base[i] = $urandom;
        du = near_value(4096);
        dv = near_value(4096);
        for (int k = 0; k < 3; k++) begin
            case (flavor)
                0: send_vertex($urandom, $urandom, $urandom, $urandom, $urandom);
                1: send_vertex(base[0] + near_value(1 << 18), base[1] + near_value(1 << 18),
                               base[2] + near_value(1 << 18), base[3] + near_value(1 << 18),
                               base[4] + near_value(1 << 18));
                // Collinear texture coordinates give a zero determinant.
                2: send_vertex($urandom, $urandom, $urandom,
                               base[3] + du * k, base[4] + dv * k);
                // Coinciding positions give zero-length vectors.
                3: send_vertex(base[0], base[1], base[2], $urandom, $urandom);
                4: send_vertex(edge_value(), edge_value(), edge_value(),
                               edge_value(), edge_value());
                default: send_vertex(near_value(8), near_value(8), near_value(8),
                                     near_value(8), near_value(8));
            endcase
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: zeros, extremes, axis-aligned unit square, mirrored UV, coincident.
        repeat (3) send_vertex(0, 0, 0, 0, 0);
        send_vertex(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_vertex(32'h7fffffff, 32'h80000000, 32'h0, 32'h80000000, 32'h7fffffff);
        send_vertex(0, 0, 0, 0, 0);
        send_vertex(32'h10000, 0, 0, 32'h10000, 0);
        send_vertex(0, 32'h10000, 0, 0, 32'h10000);
        send_vertex(0, 0, 0, 0, 0);
        send_vertex(32'h10000, 0, 0, 32'hffff0000, 0);
        send_vertex(0, 32'h10000, 0, 0, 32'h10000);
        send_vertex(5, 5, 5, 7, 7);
        send_vertex(5, 5, 5, 7, 7);
        send_vertex(5, 5, 5, 7, 7);
        send_vertex(0, 0, 0, 0, 0);
        send_vertex(32'h7fffffff, 0, 1, 1, 0);
        send_vertex(0, 1, 0, 0, 1);
        send_vertex(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_vertex(32'h80000000, 0, 0, 32'h80000000, 0);
        send_vertex(0, 32'h80000000, 32'h7fffffff, 0, 32'h80000000);

        for (int n = 7; n < TRIANGLES; n++) begin
            if (n >= QUIET_FROM) quiet = 1;
            send_triangle($urandom_range(0, 5));
        end
        s_axis_tvalid <= 0;

        while (pending != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);

        $display("Ran %0d triangles from %0d vertices; %0d results checked, %0d degenerate.",
                 TRIANGLES, 3 * TRIANGLES, results_seen, degenerate_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
